[design/pmc_pkg.sv]
// package for the ps/2 mouse packet cursor block
// holds widths, reset values, packet type, config indexes and the clamp limit function
// no dependencies
package pmc_pkg;

  // coordinate and config widths
  localparam int COORD_BITS = 13;
  localparam int CFG_BITS   = 14;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  // reset values
  localparam logic [COORD_BITS-1:0] POS_RESET     = COORD_BITS'(100);
  localparam logic [CFG_BITS-1:0]   WIDTH_RESET   = CFG_BITS'(1024);
  localparam logic [CFG_BITS-1:0]   HEIGHT_RESET  = CFG_BITS'(768);

  // header bits
  localparam int SYNC_BIT  = 3;
  localparam int LEFT_BIT  = 0;
  localparam int RIGHT_BIT = 1;

  // queue between packet assembly and cursor update
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  // config register indexes
  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } pmc_cfg_e;

  // byte position inside a packet
  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_DX     = 2'd1,
    POS_DY     = 2'd2
  } pmc_pos_e;

  // one assembled packet
  typedef struct packed {
    logic       left;
    logic       right;
    logic [7:0] dx;
    logic [7:0] dy;
  } pmc_pkt_t;

  // push request from the front
  typedef struct packed {
    logic     valid;
    pmc_pkt_t pkt;
  } pmc_push_t;

  // upper clamp for a resolution: zero counts as one, capped at the coordinate range
  function automatic logic [COORD_BITS-1:0] pmc_top(input logic [CFG_BITS-1:0] res);
    int unsigned r1;
    logic [COORD_BITS-1:0] top;
    r1 = 0;
    if (res != '0) begin
      r1 = int'(res) - 1;
    end
    if (r1 > COORD_MAX) begin
      top = COORD_BITS'(COORD_MAX);
    end else begin
      top = r1[COORD_BITS-1:0];
    end
    return top;
  endfunction

endpackage

[design/pmc_front.sv]
// front part: accepts bytes, filters non-mouse data, tracks packet sync
// pushes each completed packet into the queue; depends on pmc_pkg
module pmc_front import pmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       from_aux_i,
  input  logic       q_full_i,
  output pmc_push_t  push_o
);

  pmc_pos_e   pos_q, pos_d;
  logic [7:0] header_q, header_d;
  logic [7:0] dx_q, dx_d;
  logic       take;

  // a beat is taken whenever the queue has room
  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i && from_aux_i;

  // next position in the packet
  always_comb begin
    pos_d = pos_q;
    if (take) begin
      unique case (pos_q)
        POS_HEADER: begin
          if (rx_byte_i[SYNC_BIT]) begin
            pos_d = POS_DX;
          end
        end
        POS_DX:  pos_d = POS_DY;
        default: pos_d = POS_HEADER;
      endcase
    end
  end

  // byte capture and packet push
  always_comb begin
    header_d       = header_q;
    dx_d           = dx_q;
    push_o         = '0;
    push_o.pkt.left  = header_q[LEFT_BIT];
    push_o.pkt.right = header_q[RIGHT_BIT];
    push_o.pkt.dx    = dx_q;
    push_o.pkt.dy    = rx_byte_i;
    if (take) begin
      unique case (pos_q)
        POS_HEADER: begin
          if (rx_byte_i[SYNC_BIT]) begin
            header_d = rx_byte_i;
          end
        end
        POS_DX:  dx_d = rx_byte_i;
        default: push_o.valid = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_HEADER;
      header_q <= '0;
      dx_q     <= '0;
    end else begin
      pos_q    <= pos_d;
      header_q <= header_d;
      dx_q     <= dx_d;
    end
  end

  // a packet leaves only on its third byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> (pos_q != POS_HEADER && pos_q != POS_DX))
    else $error("packet pushed before its third byte");

  // a non-mouse byte never moves the packet position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !from_aux_i) |=> (pos_q == $past(pos_q)))
    else $error("non-mouse byte changed packet position");

endmodule

[design/pmc_queue.sv]
// short packet queue between the front and the back
// register storage with read and write pointers; depends on pmc_pkg
module pmc_queue import pmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pmc_push_t push_i,
  output logic      full_o,
  output logic      valid_o,
  output pmc_pkt_t  pkt_o,
  input  logic      pop_i
);

  pmc_pkt_t               mem_q [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_BITS:0]     count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == (QPTR_BITS+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign pkt_o   = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.pkt;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // fill count stays within the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_BITS+1)'(QDEPTH))
    else $error("queue overfilled");

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("push into full queue");

endmodule

[design/pmc_back.sv]
// back part: applies packet deltas to the cursor, clamps, holds the result register
// depends on pmc_pkg
module pmc_back import pmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pkt_valid_i,
  input  pmc_pkt_t              pkt_i,
  output logic                  pop_o,
  input  logic [CFG_BITS-1:0]   screen_width_i,
  input  logic [CFG_BITS-1:0]   screen_height_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic                  left_button_o,
  output logic                  right_button_o
);

  localparam int SUM_BITS = COORD_BITS + 2;

  logic [COORD_BITS-1:0]      pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                       out_valid_q;
  logic                       left_q, right_q;
  logic signed [SUM_BITS-1:0] nx, ny;
  logic [COORD_BITS-1:0]      top_x, top_y;

  assign pop_o = pkt_valid_i && (!out_valid_q || !out_stall_i);

  // signed delta add; y is subtracted since screen rows grow downward
  assign nx = $signed({2'b00, pos_x_q}) + SUM_BITS'($signed(pkt_i.dx));
  assign ny = $signed({2'b00, pos_y_q}) - SUM_BITS'($signed(pkt_i.dy));
  assign top_x = pmc_top(screen_width_i);
  assign top_y = pmc_top(screen_height_i);

  // clamp to 0 .. top
  always_comb begin
    if (nx < 0) begin
      pos_x_d = '0;
    end else if ($unsigned(nx) > {2'b00, top_x}) begin
      pos_x_d = top_x;
    end else begin
      pos_x_d = nx[COORD_BITS-1:0];
    end
    if (ny < 0) begin
      pos_y_d = '0;
    end else if ($unsigned(ny) > {2'b00, top_y}) begin
      pos_y_d = top_y;
    end else begin
      pos_y_d = ny[COORD_BITS-1:0];
    end
  end

  // cursor state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= POS_RESET;
      pos_y_q     <= POS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // button payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      left_q  <= pkt_i.left;
      right_q <= pkt_i.right;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_x_o     = pos_x_q;
  assign cursor_y_o     = pos_y_q;
  assign left_button_o  = left_q;
  assign right_button_o = right_q;

  // a new result only follows a packet taken from the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop_o))
    else $error("result without packet");

  // never pop while a stalled result is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("result overwritten while stalled");

endmodule

[design/ps2_mouse_packet_cursor.sv]
// ps/2 mouse packet cursor: one byte beat per cycle in, one result beat per full packet.
// bytes stall while the queue is full. A completed packet goes into the queue, then into
// the result register. throughput: one byte per cycle unless the queue is full; the 2-entry
// packet queue and the result register let the byte side run while a result waits on a stall.
// reset: packet sync lost, cursor at (100,100), resolution 1024 x 768, queue empty.
// depends on pmc_pkg, pmc_front, pmc_queue, pmc_back
module ps2_mouse_packet_cursor import pmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  input  logic                  from_aux_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic                  left_button_o,
  output logic                  right_button_o,
  input  logic                  cfg_we_i,
  input  pmc_cfg_e              cfg_index_i,
  input  logic [CFG_BITS-1:0]   cfg_data_i
);

  logic [CFG_BITS-1:0] screen_width_q, screen_height_q;
  pmc_push_t           push;
  logic                q_full, q_valid, pop;
  pmc_pkt_t            q_pkt;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= WIDTH_RESET;
      screen_height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .from_aux_i (from_aux_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  pmc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pkt_o   (q_pkt),
    .pop_i   (pop)
  );

  pmc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pkt_valid_i     (q_valid),
    .pkt_i           (q_pkt),
    .pop_o           (pop),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .left_button_o   (left_button_o),
    .right_button_o  (right_button_o)
  );

endmodule

[tb/sv/tb_ps2_mouse_packet_cursor.sv]
// testbench for ps2_mouse_packet_cursor: drives aux-port byte beats and checks cursor results
// against a cycle-free predictor of packet assembly, relative moves and screen clamping
// depends on pmc_pkg and the ps2_mouse_packet_cursor design files
module tb_ps2_mouse_packet_cursor;
  import pmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned IDLE_PCT    = 36;

  typedef struct {
    logic [7:0] data;
    logic       aux;
  } aux_beat_t;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  right;
  } cursor_report_t;

  // clock, reset and block ports
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            rx_byte_i      = '0;
  logic                  from_aux_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [COORD_BITS-1:0] cursor_x_o;
  logic [COORD_BITS-1:0] cursor_y_o;
  logic                  left_button_o;
  logic                  right_button_o;
  logic                  cfg_we_i       = 1'b0;
  pmc_cfg_e              cfg_index_i    = CFG_SCREEN_WIDTH;
  logic [CFG_BITS-1:0]   cfg_data_i     = '0;

  // stimulus and expectation stores
  aux_beat_t      pending_beats[$];
  cursor_report_t cursor_expect[$];
  aux_beat_t      next_beat;
  cursor_report_t got_report;
  cursor_report_t want_report;
  logic           steady_flow = 1'b0;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;

  // predictor state: config mirror, packet assembly, cursor
  logic [CFG_BITS-1:0]   screen_w = WIDTH_RESET;
  logic [CFG_BITS-1:0]   screen_h = HEIGHT_RESET;
  pmc_pos_e              byte_pos = POS_HEADER;
  logic [7:0]            hdr_byte = '0;
  logic [7:0]            dx_byte  = '0;
  logic [COORD_BITS-1:0] cur_x    = POS_RESET;
  logic [COORD_BITS-1:0] cur_y    = POS_RESET;

  ps2_mouse_packet_cursor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .from_aux_i     (from_aux_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cursor_x_o     (cursor_x_o),
    .cursor_y_o     (cursor_y_o),
    .left_button_o  (left_button_o),
    .right_button_o (right_button_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // clamp to 0 .. res-1; zero res acts as one, top capped at the coordinate range
  function automatic logic [COORD_BITS-1:0] clamp_to_screen(int v, logic [CFG_BITS-1:0] res);
    int top;
    top = (res == '0) ? 0 : int'(res) - 1;
    if (top > COORD_MAX) top = COORD_MAX;
    if (v < 0) v = 0;
    else if (v > top) v = top;
    return COORD_BITS'(v);
  endfunction

  // packet assembly and cursor update for one accepted byte beat
  function automatic void track_mouse_byte(logic [7:0] data, logic aux);
    cursor_report_t rep;
    int nx;
    int ny;
    if (!aux) return;
    case (byte_pos)
      POS_HEADER: begin
        // resync: a header must carry the always-one bit
        if (data[SYNC_BIT]) begin
          hdr_byte = data;
          byte_pos = POS_DX;
        end
      end
      POS_DX: begin
        dx_byte  = data;
        byte_pos = POS_DY;
      end
      default: begin
        byte_pos = POS_HEADER;
        nx = int'(cur_x) + int'($signed(dx_byte));
        // mouse y points up, screen y points down
        ny = int'(cur_y) - int'($signed(data));
        cur_x = clamp_to_screen(nx, screen_w);
        cur_y = clamp_to_screen(ny, screen_h);
        rep.x     = cur_x;
        rep.y     = cur_y;
        rep.left  = hdr_byte[LEFT_BIT];
        rep.right = hdr_byte[RIGHT_BIT];
        cursor_expect.push_back(rep);
      end
    endcase
  endfunction

  // byte driver: predicts on acceptance, then loads the next beat or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
      from_aux_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) track_mouse_byte(rx_byte_i, from_aux_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_beats.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_beat  = pending_beats.pop_front();
          in_valid_i <= 1'b1;
          rx_byte_i  <= next_beat.data;
          from_aux_i <= next_beat.aux;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each accepted beat with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_report.x     = cursor_x_o;
        got_report.y     = cursor_y_o;
        got_report.left  = left_button_o;
        got_report.right = right_button_o;
        if (cursor_expect.size() == 0) begin
          $error("unexpected result beat: x %0d y %0d", got_report.x, got_report.y);
          error_count++;
        end else begin
          want_report = cursor_expect.pop_front();
          if (got_report.x !== want_report.x) begin
            $error("cursor_x expected %0d got %0d", want_report.x, got_report.x);
            error_count++;
          end
          if (got_report.y !== want_report.y) begin
            $error("cursor_y expected %0d got %0d", want_report.y, got_report.y);
            error_count++;
          end
          if (got_report.left !== want_report.left) begin
            $error("left_button expected %0b got %0b", want_report.left, got_report.left);
            error_count++;
          end
          if (got_report.right !== want_report.right) begin
            $error("right_button expected %0b got %0b", want_report.right, got_report.right);
            error_count++;
          end
        end
      end
      out_stall_i <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_beat(logic [7:0] data, logic aux);
    aux_beat_t b;
    b.data = data;
    b.aux  = aux;
    pending_beats.push_back(b);
  endtask

  // three aux bytes, each preceded at random by a non-aux byte
  task automatic queue_packet(logic [7:0] hdr, logic [7:0] dx, logic [7:0] dy,
                              int unsigned noise_pct);
    logic [7:0] pkt [3];
    pkt[0] = hdr;
    pkt[1] = dx;
    pkt[2] = dy;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 99) < noise_pct) queue_beat(8'($urandom_range(0, 255)), 1'b0);
      queue_beat(pkt[i], 1'b1);
    end
  endtask

  // delta with an optional pull toward large positive or large negative moves
  function automatic logic [7:0] rand_delta(int bias);
    if (bias != 0 && $urandom_range(0, 99) < 75) begin
      return (bias > 0) ? 8'($urandom_range(96, 127)) : 8'($urandom_range(128, 160));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed packets, some headers without the sync bit, some stray bytes
  task automatic queue_traffic(int unsigned n_aux, int bias_x, int bias_y);
    int unsigned sent;
    int unsigned roll;
    logic [7:0]  hdr;
    sent = 0;
    while (sent < n_aux) begin
      roll = $urandom_range(0, 99);
      hdr  = 8'($urandom_range(0, 255));
      if (roll < 80) begin
        hdr[SYNC_BIT] = 1'b1;
        queue_packet(hdr, rand_delta(bias_x), rand_delta(bias_y), 15);
        sent += 3;
      end else if (roll < 90) begin
        hdr[SYNC_BIT] = 1'b0;
        queue_beat(hdr, 1'b1);
        sent++;
      end else begin
        queue_beat(hdr, 1'b1);
        sent++;
      end
    end
  endtask

  // hold off until every beat is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || cursor_expect.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(pmc_cfg_e idx, logic [CFG_BITS-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) screen_w = value;
    else screen_h = value;
    @(negedge clk_i);
  endtask

  task automatic set_screen(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
  endtask

  function automatic logic [CFG_BITS-1:0] pick_res();
    if ($urandom_range(0, 1) == 0) return CFG_BITS'($urandom_range(1, 400));
    return CFG_BITS'($urandom_range(1, 8192));
  endfunction

  // test sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset resolution, ignored and dropped bytes, extreme deltas and buttons
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h00, 1'b1);
    queue_beat(8'hF7, 1'b1);
    queue_packet(8'h08, 8'h00, 8'h00, 0);
    queue_packet(8'hFF, 8'h7F, 8'h80, 0);
    queue_packet(8'h09, 8'h80, 8'h7F, 0);
    queue_beat(8'h0A, 1'b1);
    queue_beat(8'h55, 1'b0);
    queue_beat(8'h80, 1'b1);
    queue_beat(8'hAA, 1'b0);
    queue_beat(8'h7F, 1'b1);
    queue_packet(8'hCE, 8'h01, 8'hFF, 0);
    wait_drained();

    // resolution above the coordinate range: ramp both axes to the top clamp, no idling
    set_screen(CFG_BITS'(16383), CFG_BITS'(16383));
    steady_flow = 1'b1;
    repeat (66) queue_packet(8'($urandom_range(0, 255)) | 8'h08, 8'h7F, 8'h80, 0);
    wait_drained();
    steady_flow = 1'b0;

    // largest legal resolution, cursor near the far corner
    set_screen(CFG_BITS'(8192), CFG_BITS'(8192));
    queue_traffic(100, 1, -1);
    wait_drained();

    // lowered resolution leaves the cursor outside until the next packet
    set_screen(CFG_BITS'(50), CFG_BITS'(1));
    queue_traffic(60, 0, 0);
    wait_drained();

    // zero resolution holds both coordinates at zero
    set_screen('0, '0);
    queue_traffic(40, 0, 0);
    wait_drained();

    set_screen(CFG_BITS'(1), CFG_BITS'(16383));
    queue_traffic(40, 1, -1);
    wait_drained();

    // random resolutions
    repeat (2) begin
      set_screen(pick_res(), pick_res());
      queue_traffic(60, 0, 0);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[ps2_mouse_packet_cursor.f]
design/pmc_pkg.sv
design/pmc_front.sv
design/pmc_queue.sv
design/pmc_back.sv
design/ps2_mouse_packet_cursor.sv
tb/sv/tb_ps2_mouse_packet_cursor.sv
